// ===== src/assert_macros.svh =====
// Assertion helpers for the RTL; only bsr_back.sv includes them.
// All properties are clocked on i_clk and disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property checked at every rising edge.
`define BSR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("bitstream reader assertion failed");

// Condition that must never hold.
`define BSR_NEVER(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("bitstream reader forbidden condition seen");

`endif

// ===== src/bsr_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitstream reader package
// Shared constants, command codes and the queued command type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsr_pkg;

    localparam int BUF_BYTES = 65536;
    localparam int ADDR_W    = $clog2(BUF_BYTES);
    localparam int SIZE_W    = 17;
    localparam int POS_W     = 20;
    localparam logic [SIZE_W-1:0] BUF_SIZE = SIZE_W'(BUF_BYTES);
    localparam logic [POS_W-1:0]  MAX_BITS = POS_W'(BUF_BYTES * 8);

    // Raw action codes on the input port
    localparam logic [3:0] ACT_LOAD  = 4'd0;
    localparam logic [3:0] ACT_READ  = 4'd1;
    localparam logic [3:0] ACT_UE    = 4'd2;
    localparam logic [3:0] ACT_SE    = 4'd3;
    localparam logic [3:0] ACT_SKIP  = 4'd4;
    localparam logic [3:0] ACT_SETP  = 4'd5;
    localparam logic [3:0] ACT_ALIGN = 4'd6;
    localparam logic [3:0] ACT_SRCH  = 4'd7;
    localparam logic [3:0] ACT_NEXT  = 4'd8;

    typedef enum logic [3:0] {
        OP_LOAD, OP_READ, OP_UE, OP_SE, OP_SKIP,
        OP_SETP, OP_ALIGN, OP_SRCH, OP_NEXT, OP_NONE
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [15:0]         load_address;
        logic [7:0]          load_byte;
        logic [5:0]          bit_count;
        logic                peek;
        logic signed [19:0]  skip_bits;
        logic signed [16:0]  byte_position;
        logic [31:0]         search_code;
        logic [31:0]         search_mask;
    } t_item;

endpackage

// ===== src/bsr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== src/bsr_front.sv =====
// ----------------------------------------------------------------------------
// Bitstream reader front end
// Accepts command beats, decodes the action and holds them in a
// two-entry queue for the execution unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsr_front import bsr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [3:0]          i_action,
    input  logic [15:0]         i_load_address,
    input  logic [7:0]          i_load_byte,
    input  logic [5:0]          i_bit_count,
    input  logic                i_peek,
    input  logic signed [19:0]  i_skip_bits,
    input  logic signed [16:0]  i_byte_position,
    input  logic [31:0]         i_search_code,
    input  logic [31:0]         i_search_mask,
    output logic                o_item_valid,
    output t_item               o_item,
    input  logic                i_pop
);

    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_item      w_item;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_item               = '0;
        w_item.load_address  = i_load_address;
        w_item.load_byte     = i_load_byte;
        w_item.bit_count     = i_bit_count;
        w_item.peek          = i_peek;
        w_item.skip_bits     = i_skip_bits;
        w_item.byte_position = i_byte_position;
        w_item.search_code   = i_search_code;
        w_item.search_mask   = i_search_mask;
        case (i_action)
            ACT_LOAD:  w_item.op = OP_LOAD;
            ACT_READ:  w_item.op = OP_READ;
            ACT_UE:    w_item.op = OP_UE;
            ACT_SE:    w_item.op = OP_SE;
            ACT_SKIP:  w_item.op = OP_SKIP;
            ACT_SETP:  w_item.op = OP_SETP;
            ACT_ALIGN: w_item.op = OP_ALIGN;
            ACT_SRCH:  w_item.op = OP_SRCH;
            ACT_NEXT:  w_item.op = OP_NEXT;
            default:   w_item.op = OP_NONE;
        endcase
    end

    assign o_ready      = (r_cnt != 2'd2);
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];
    assign w_push       = i_valid && o_ready;
    assign w_pop        = i_pop && o_item_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

// ===== src/bsr_back.sv =====
// ----------------------------------------------------------------------------
// Bitstream reader execution unit
// Runs one queued command at a time against the byte store, one byte
// fetch per step, and holds the result in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bsr_back import bsr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [16:0]         i_cfg_wdata,
    input  logic                i_item_valid,
    input  t_item               i_item,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [31:0]         o_value,
    output logic signed [31:0]  o_signed_value,
    output logic                o_found,
    output logic                o_code_error,
    output logic [19:0]         o_bit_position,
    output logic [19:0]         o_remaining_bits
);

    typedef enum logic [3:0] {
        S_IDLE, S_BIT, S_BITD, S_FIN, S_SRCH, S_SRCHD, S_NB, S_NBD, S_DONE
    } t_state;

    typedef enum logic [1:0] {PH_RD, PH_PRE, PH_SUF} t_phase;

    t_state              r_state;
    t_phase              r_phase;
    t_op                 r_op;
    logic [SIZE_W-1:0]   r_cfg;
    logic [POS_W-1:0]    r_pos;
    logic [POS_W-1:0]    r_saved;
    logic                r_peek;
    logic [31:0]         r_val;
    logic [31:0]         r_sval;
    logic [5:0]          r_cnt;
    logic [5:0]          r_zeros;
    logic                r_err;
    logic                r_found;
    logic [SIZE_W-1:0]   r_idx;
    logic [SIZE_W-1:0]   r_start;
    logic [31:0]         r_win;
    logic [2:0]          r_wcnt;
    logic [31:0]         r_code;
    logic [31:0]         r_mask;

    logic [SIZE_W-1:0]   w_sz;
    logic [POS_W-1:0]    w_tot;
    logic                w_end;
    logic                w_ram_we;
    logic [ADDR_W-1:0]   w_raddr;
    logic [7:0]          w_rdata;
    logic                w_bit;
    logic signed [21:0]  w_np;
    logic [POS_W-1:0]    w_skip_pos;
    logic [POS_W-1:0]    w_set_pos;
    logic [POS_W-1:0]    w_align_pos;
    logic [POS_W-1:0]    w_srch_pos;
    logic [31:0]         w_ue;
    logic [31:0]         w_win;
    logic [2:0]          w_wcnt;
    logic [SIZE_W-1:0]   w_idx1;

    assign w_sz   = (r_cfg > BUF_SIZE) ? BUF_SIZE : r_cfg;
    assign w_tot  = {w_sz, 3'b000};
    assign w_end  = (r_pos >= w_tot);
    assign o_pop  = (r_state == S_IDLE) && i_item_valid;
    assign w_ram_we = o_pop && (i_item.op == OP_LOAD);

    always_comb begin
        case (r_state)
            S_BIT:   w_raddr = r_pos[ADDR_W+2:3];
            default: w_raddr = r_idx[ADDR_W-1:0];
        endcase
    end

    bsr_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (i_item.load_address[ADDR_W-1:0]),
        .i_wdata (i_item.load_byte),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_bit = w_rdata[3'd7 - r_pos[2:0]];

    // Clamp skip target to the buffer
    always_comb begin
        w_np = $signed({2'b00, r_pos}) + $signed({{2{i_item.skip_bits[19]}}, i_item.skip_bits});
        if (w_np[21]) begin
            w_skip_pos = '0;
        end else if (w_np[20:0] > {1'b0, w_tot}) begin
            w_skip_pos = w_tot;
        end else begin
            w_skip_pos = w_np[19:0];
        end
    end

    always_comb begin
        if (i_item.byte_position[16]) begin
            w_set_pos = '0;
        end else if ({1'b0, i_item.byte_position[15:0]} < w_sz) begin
            w_set_pos = {1'b0, i_item.byte_position[15:0], 3'b000};
        end else begin
            w_set_pos = w_tot;
        end
        if (r_pos[2:0] != 3'd0) begin
            w_align_pos = {r_pos[19:3] + 17'd1, 3'b000};
        end else begin
            w_align_pos = r_pos;
        end
        w_srch_pos = (i_item.byte_position == '1) ? w_align_pos : w_set_pos;
    end

    assign w_ue   = ((32'd1 << r_zeros[4:0]) - 32'd1) + r_val;
    assign w_win  = {r_win[23:0], w_rdata};
    assign w_wcnt = (r_wcnt == 3'd4) ? 3'd4 : r_wcnt + 3'd1;
    assign w_idx1 = r_idx + 17'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg   <= '0;
            r_pos   <= '0;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            // drop the beat once taken, unless a new one replaces it now
            if (o_valid && i_ready && r_state != S_DONE) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_op    <= i_item.op;
                        r_val   <= '0;
                        r_sval  <= '0;
                        r_err   <= 1'b0;
                        r_found <= 1'b0;
                        r_peek  <= i_item.peek;
                        r_saved <= r_pos;
                        r_zeros <= '0;
                        r_wcnt  <= '0;
                        r_code  <= i_item.search_code;
                        r_mask  <= i_item.search_mask;
                        case (i_item.op)
                            OP_READ: begin
                                r_phase <= PH_RD;
                                r_cnt   <= (i_item.bit_count > 6'd32) ? 6'd32
                                                                      : i_item.bit_count;
                                r_state <= (i_item.bit_count != 6'd0) ? S_BIT : S_DONE;
                            end
                            OP_UE, OP_SE: begin
                                r_phase <= PH_PRE;
                                r_state <= S_BIT;
                            end
                            OP_SKIP: begin
                                r_pos   <= w_skip_pos;
                                r_state <= S_DONE;
                            end
                            OP_SETP: begin
                                r_pos   <= w_set_pos;
                                r_state <= S_DONE;
                            end
                            OP_ALIGN: begin
                                r_pos   <= w_align_pos;
                                r_state <= S_DONE;
                            end
                            OP_SRCH: begin
                                r_pos   <= w_srch_pos;
                                r_idx   <= w_srch_pos[19:3];
                                r_start <= w_srch_pos[19:3];
                                r_state <= S_SRCH;
                            end
                            OP_NEXT: begin
                                r_cnt <= (i_item.bit_count > 6'd4) ? 6'd4 : i_item.bit_count;
                                r_idx <= r_pos[19:3];
                                r_state <= (i_item.bit_count != 6'd0) ? S_NB : S_DONE;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_BIT: begin
                    if (!w_end) begin
                        r_state <= S_BITD;
                    end else if (r_phase == PH_PRE) begin
                        // prefix stops at the end of the buffer
                        r_phase <= PH_SUF;
                        r_cnt   <= r_zeros;
                        r_state <= (r_zeros == 6'd0) ? S_FIN : S_BIT;
                    end else begin
                        r_val <= {r_val[30:0], 1'b0};
                        r_cnt <= r_cnt - 6'd1;
                        if (r_cnt == 6'd1) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_BITD: begin
                    r_pos <= r_pos + 20'd1;
                    if (r_phase == PH_PRE) begin
                        if (w_bit) begin
                            r_phase <= PH_SUF;
                            r_cnt   <= r_zeros;
                            r_state <= (r_zeros == 6'd0) ? S_FIN : S_BIT;
                        end else if (r_zeros == 6'd31) begin
                            r_err   <= 1'b1;
                            r_val   <= (r_op == OP_UE) ? '1 : '0;
                            r_state <= S_DONE;
                        end else begin
                            r_zeros <= r_zeros + 6'd1;
                            r_state <= S_BIT;
                        end
                    end else begin
                        r_val   <= {r_val[30:0], w_bit};
                        r_cnt   <= r_cnt - 6'd1;
                        r_state <= (r_cnt == 6'd1) ? S_FIN : S_BIT;
                    end
                end
                S_FIN: begin
                    r_state <= S_DONE;
                    case (r_op)
                        OP_READ: begin
                            if (r_peek) begin
                                r_pos <= r_saved;
                            end
                        end
                        OP_UE: r_val <= w_ue;
                        OP_SE: begin
                            r_val <= '0;
                            if (w_ue[0]) begin
                                r_sval <= {1'b0, w_ue[31:1]} + 32'd1;
                            end else begin
                                r_sval <= 32'd0 - {1'b0, w_ue[31:1]};
                            end
                        end
                        default: ;
                    endcase
                end
                S_SRCH: begin
                    if (r_idx >= w_sz) begin
                        // no match: return to the start byte
                        r_pos   <= (r_start < w_sz) ? {r_start, 3'b000} : w_tot;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SRCHD;
                    end
                end
                S_SRCHD: begin
                    r_win  <= w_win;
                    r_wcnt <= w_wcnt;
                    r_idx  <= w_idx1;
                    if (w_wcnt == 3'd4 && (w_win & r_mask) == r_code) begin
                        r_found <= 1'b1;
                        r_pos   <= {r_idx - 17'd3, 3'b000};
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SRCH;
                    end
                end
                S_NB, S_NBD: begin
                    if (r_state == S_NB && r_idx < w_sz) begin
                        r_state <= S_NBD;
                    end else begin
                        r_val <= (r_state == S_NBD) ? {r_val[23:0], w_rdata}
                                                    : {r_val[23:0], 8'h00};
                        r_idx <= w_idx1;
                        r_cnt <= r_cnt - 6'd1;
                        r_state <= (r_cnt == 6'd1) ? S_DONE : S_NB;
                    end
                end
                S_DONE: begin
                    if (!o_valid || i_ready) begin
                        o_valid          <= 1'b1;
                        o_value          <= r_val;
                        o_signed_value   <= r_sval;
                        o_found          <= r_found;
                        o_code_error     <= r_err;
                        o_bit_position   <= r_pos;
                        o_remaining_bits <= (w_tot > r_pos) ? w_tot - r_pos : '0;
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `BSR_NEVER(a_pos_range, r_pos > MAX_BITS)
    `BSR_NEVER(a_zeros_range, r_zeros > 6'd31)
    `BSR_ASSERT(a_found_search, (r_state == S_DONE && r_found) |-> (r_op == OP_SRCH))
    `BSR_ASSERT(a_result_held, (o_valid && !i_ready) |=> (o_valid && $stable(o_bit_position)))

endmodule

// ===== src/bitstream_reader_exp_golomb.sv =====
// ----------------------------------------------------------------------------
// Bitstream reader with Exp-Golomb decode
// Byte buffer with MSB-first bit reads, ue/se decode, skip, seek, align,
// masked start-code search and byte peek.
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// command   in         i_valid / o_ready      i_action .. i_search_mask
// result    out        o_valid / i_ready      o_value .. o_remaining_bits
// config    in         i_cfg_we (no wait)     i_cfg_wdata (buffer_bytes)
//
// Load, skip, setpos, align and unused actions do not read the store; a read
// fetches one byte per bit, ue/se one per prefix and suffix bit, search and
// nextbytes one per byte, all through the single byte-store read port.
// Reset: synchronous, active low; no clearing pass, the store starts unwritten.
// A two-entry command queue keeps accepting, until full, while a result waits to be taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitstream_reader_exp_golomb import bsr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [16:0]         i_cfg_wdata,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [3:0]          i_action,
    input  logic [15:0]         i_load_address,
    input  logic [7:0]          i_load_byte,
    input  logic [5:0]          i_bit_count,
    input  logic                i_peek,
    input  logic signed [19:0]  i_skip_bits,
    input  logic signed [16:0]  i_byte_position,
    input  logic [31:0]         i_search_code,
    input  logic [31:0]         i_search_mask,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [31:0]         o_value,
    output logic signed [31:0]  o_signed_value,
    output logic                o_found,
    output logic                o_code_error,
    output logic [19:0]         o_bit_position,
    output logic [19:0]         o_remaining_bits
);

    logic  w_item_valid;
    t_item w_item;
    logic  w_pop;

    bsr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_action        (i_action),
        .i_load_address  (i_load_address),
        .i_load_byte     (i_load_byte),
        .i_bit_count     (i_bit_count),
        .i_peek          (i_peek),
        .i_skip_bits     (i_skip_bits),
        .i_byte_position (i_byte_position),
        .i_search_code   (i_search_code),
        .i_search_mask   (i_search_mask),
        .o_item_valid    (w_item_valid),
        .o_item          (w_item),
        .i_pop           (w_pop)
    );

    bsr_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_item_valid     (w_item_valid),
        .i_item           (w_item),
        .o_pop            (w_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_value          (o_value),
        .o_signed_value   (o_signed_value),
        .o_found          (o_found),
        .o_code_error     (o_code_error),
        .o_bit_position   (o_bit_position),
        .o_remaining_bits (o_remaining_bits)
    );

endmodule
